FILE: rtl/mnlb_pkg.sv
// shared types, constants and microcode table of the morse number led blinker
package mnlb_pkg;

    // field and datapath widths
    localparam int NUM_W    = 20;
    localparam int TICK_W   = 24;
    localparam int DIG_W    = 4;
    localparam int PAT_W    = 5;
    localparam int SYM_W    = 3;
    localparam int UPC_W    = 3;
    localparam int CFG_AW   = 4;
    localparam int CFG_DW   = 32;
    localparam int REG_IW   = 2;

    localparam int MAX_DIGITS_DEF = 6;

    // reset values of the duration registers
    localparam logic [TICK_W-1:0] DOT_RST  = 24'd400000;
    localparam logic [TICK_W-1:0] DASH_RST = 24'd800000;
    localparam logic [TICK_W-1:0] GAP_RST  = 24'd600000;
    localparam logic [TICK_W-1:0] MARK_RST = 24'd800000;

    // divide by ten: q = (n * RECIP) >> RECIP_SHIFT, exact for n below 2**22
    localparam logic [NUM_W-1:0] RECIP       = 20'd838861;
    localparam int               RECIP_SHIFT = 23;

    // register indexes
    localparam logic [REG_IW-1:0] REG_DOT  = 2'd0;
    localparam logic [REG_IW-1:0] REG_DASH = 2'd1;
    localparam logic [REG_IW-1:0] REG_GAP  = 2'd2;
    localparam logic [REG_IW-1:0] REG_MARK = 2'd3;

    // input item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // microprogram steps
    localparam logic [UPC_W-1:0] UPC_IDLE    = 3'd0;
    localparam logic [UPC_W-1:0] UPC_EXTRACT = 3'd1;
    localparam logic [UPC_W-1:0] UPC_SYM     = 3'd2;
    localparam logic [UPC_W-1:0] UPC_GAP     = 3'd3;
    localparam logic [UPC_W-1:0] UPC_RED1    = 3'd4;
    localparam logic [UPC_W-1:0] UPC_DARK1   = 3'd5;
    localparam logic [UPC_W-1:0] UPC_RED2    = 3'd6;
    localparam logic [UPC_W-1:0] UPC_DARK2   = 3'd7;

    // led select
    localparam logic [1:0] LED_OFF = 2'd0;
    localparam logic [1:0] LED_RED = 2'd1;
    localparam logic [1:0] LED_SYM = 2'd2;

    // duration select
    localparam logic [1:0] DUR_SYM  = 2'd0;
    localparam logic [1:0] DUR_GAP  = 2'd1;
    localparam logic [1:0] DUR_MARK = 2'd2;

    // jump conditions
    localparam logic [1:0] COND_ALWAYS   = 2'd0;
    localparam logic [1:0] COND_DIV_DONE = 2'd1;
    localparam logic [1:0] COND_SYM_MORE = 2'd2;
    localparam logic [1:0] COND_LAST     = 2'd3;

    // step actions
    localparam logic [2:0] ACT_IDLE       = 3'd0;
    localparam logic [2:0] ACT_DIV        = 3'd1;
    localparam logic [2:0] ACT_NONE       = 3'd2;
    localparam logic [2:0] ACT_INC_SYM    = 3'd3;
    localparam logic [2:0] ACT_NEXT_DIGIT = 3'd4;

    typedef struct packed {
        logic             kind;
        logic [NUM_W-1:0] number;
    } t_in_item;

    typedef struct packed {
        logic red_on;
        logic blue_on;
        logic green_on;
        logic busy_res;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0] dot_ticks;
        logic [TICK_W-1:0] dash_ticks;
        logic [TICK_W-1:0] gap_ticks;
        logic [TICK_W-1:0] mark_ticks;
    } t_cfg;

    // one control word
    typedef struct packed {
        logic [1:0]       led;
        logic [1:0]       dur;
        logic [1:0]       cond;
        logic [2:0]       act;
        logic [UPC_W-1:0] nxt_t;
        logic [UPC_W-1:0] nxt_f;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        logic start;
        logic div;
        logic inc_sym;
        logic next_digit;
    } t_dp_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic div_done;
        logic first_dash;
        logic sym_more;
        logic last_digit;
        logic is_dash;
    } t_dp_stat;

    function automatic t_uword uw(input logic [1:0] led, input logic [1:0] dur,
                                  input logic [1:0] cond, input logic [2:0] act,
                                  input logic [UPC_W-1:0] nxt_t,
                                  input logic [UPC_W-1:0] nxt_f);
        t_uword w;
        w.led   = led;
        w.dur   = dur;
        w.cond  = cond;
        w.act   = act;
        w.nxt_t = nxt_t;
        w.nxt_f = nxt_f;
        return w;
    endfunction

    // microprogram rom
    function automatic t_uword ucode(input logic [UPC_W-1:0] upc);
        t_uword w;
        unique case (upc)
            UPC_IDLE:    w = uw(LED_OFF, DUR_MARK, COND_ALWAYS,   ACT_IDLE,
                                UPC_EXTRACT, UPC_IDLE);
            UPC_EXTRACT: w = uw(LED_OFF, DUR_MARK, COND_DIV_DONE, ACT_DIV,
                                UPC_SYM, UPC_EXTRACT);
            UPC_SYM:     w = uw(LED_SYM, DUR_SYM,  COND_ALWAYS,   ACT_NONE,
                                UPC_GAP, UPC_GAP);
            UPC_GAP:     w = uw(LED_OFF, DUR_GAP,  COND_SYM_MORE, ACT_INC_SYM,
                                UPC_SYM, UPC_RED1);
            UPC_RED1:    w = uw(LED_RED, DUR_MARK, COND_ALWAYS,   ACT_NONE,
                                UPC_DARK1, UPC_DARK1);
            UPC_DARK1:   w = uw(LED_OFF, DUR_MARK, COND_LAST,     ACT_NONE,
                                UPC_RED2, UPC_DARK2);
            UPC_RED2:    w = uw(LED_RED, DUR_MARK, COND_ALWAYS,   ACT_NONE,
                                UPC_DARK2, UPC_DARK2);
            UPC_DARK2:   w = uw(LED_OFF, DUR_MARK, COND_LAST,     ACT_NEXT_DIGIT,
                                UPC_IDLE, UPC_SYM);
        endcase
        return w;
    endfunction

    // morse code of a digit, msb played first, 1 is a dash
    function automatic logic [PAT_W-1:0] digit_code(input logic [DIG_W-1:0] d);
        logic [PAT_W-1:0] c;
        unique case (d)
            4'd0:    c = 5'b11111;
            4'd1:    c = 5'b01111;
            4'd2:    c = 5'b00111;
            4'd3:    c = 5'b00011;
            4'd4:    c = 5'b00001;
            4'd5:    c = 5'b00000;
            4'd6:    c = 5'b10000;
            4'd7:    c = 5'b11000;
            4'd8:    c = 5'b11100;
            4'd9:    c = 5'b11110;
            default: c = 5'b00000;
        endcase
        return c;
    endfunction

    // largest number with n decimal digits
    function automatic logic [63:0] pow10_m1(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++) begin
            p = p * 64'd10;
        end
        return p - 64'd1;
    endfunction

endpackage

FILE: rtl/mnlb_cfg.sv
// apb register bank holding the four duration registers
module mnlb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mnlb_pkg::CFG_AW-1:0]   paddr,
    input  logic [mnlb_pkg::CFG_DW-1:0]   pwdata,
    output logic [mnlb_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output mnlb_pkg::t_cfg                o_cfg
);
    import mnlb_pkg::*;

    t_cfg              r_cfg;
    logic              w_wr;
    logic [REG_IW-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[CFG_AW-1:2];
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_ticks  <= DOT_RST;
            r_cfg.dash_ticks <= DASH_RST;
            r_cfg.gap_ticks  <= GAP_RST;
            r_cfg.mark_ticks <= MARK_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DOT:  r_cfg.dot_ticks  <= pwdata[TICK_W-1:0];
                REG_DASH: r_cfg.dash_ticks <= pwdata[TICK_W-1:0];
                REG_GAP:  r_cfg.gap_ticks  <= pwdata[TICK_W-1:0];
                REG_MARK: r_cfg.mark_ticks <= pwdata[TICK_W-1:0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            REG_DOT:  prdata = CFG_DW'(r_cfg.dot_ticks);
            REG_DASH: prdata = CFG_DW'(r_cfg.dash_ticks);
            REG_GAP:  prdata = CFG_DW'(r_cfg.gap_ticks);
            REG_MARK: prdata = CFG_DW'(r_cfg.mark_ticks);
        endcase
    end

endmodule

FILE: rtl/mnlb_dp.sv
// datapath: digit extraction, digit store, symbol pattern and counters
module mnlb_dp #(
    parameter int MAX_DIGITS = mnlb_pkg::MAX_DIGITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mnlb_pkg::NUM_W-1:0]  i_number,
    input  mnlb_pkg::t_dp_ctrl          i_ctrl,
    output mnlb_pkg::t_dp_stat          o_stat
);
    import mnlb_pkg::*;

    localparam int          CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int          IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [63:0] LIMIT = pow10_m1(MAX_DIGITS);

    logic [DIG_W-1:0]   r_store [MAX_DIGITS];
    logic [NUM_W-1:0]   r_work;
    logic [CNT_W-1:0]   r_left;
    logic [PAT_W-1:0]   r_pattern;
    logic [SYM_W-1:0]   r_sym;

    logic [NUM_W-1:0]   w_clamped;
    logic [2*NUM_W-1:0] w_prod;
    logic [NUM_W-1:0]   w_quot;
    logic [NUM_W-1:0]   w_q10;
    logic [NUM_W-1:0]   w_rem_full;
    logic [DIG_W-1:0]   w_rem;
    logic [PAT_W-1:0]   w_rem_code;
    logic [CNT_W-1:0]   w_rd;
    logic [PAT_W-1:0]   w_rd_code;
    logic [SYM_W-1:0]   w_bit;

    // clamp to the largest number that fits the digit store
    assign w_clamped = (64'(i_number) > LIMIT) ? LIMIT[NUM_W-1:0] : i_number;

    // one decimal digit per step through a reciprocal multiply
    assign w_prod     = r_work * RECIP;
    assign w_quot     = NUM_W'(w_prod[2*NUM_W-1:RECIP_SHIFT]);
    assign w_q10      = (w_quot << 3) + (w_quot << 1);
    assign w_rem_full = r_work - w_q10;
    assign w_rem      = w_rem_full[DIG_W-1:0];
    assign w_rem_code = digit_code(w_rem);

    // next digit down, read from the store
    assign w_rd      = r_left - CNT_W'(2);
    assign w_rd_code = digit_code(r_store[w_rd[IDX_W-1:0]]);

    // status back to the sequencer
    assign w_bit             = SYM_W'(4) - r_sym;
    assign o_stat.div_done   = (w_quot == '0) || (r_left == CNT_W'(MAX_DIGITS - 1));
    assign o_stat.first_dash = w_rem_code[PAT_W-1];
    assign o_stat.sym_more   = r_sym < SYM_W'(4);
    assign o_stat.last_digit = r_left == CNT_W'(1);
    assign o_stat.is_dash    = (r_sym < SYM_W'(5)) ? r_pattern[w_bit] : r_pattern[0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_pattern <= '0;
            r_sym     <= '0;
        end else if (i_ctrl.start) begin
            r_left <= '0;
        end else if (i_ctrl.div) begin
            r_left <= r_left + CNT_W'(1);
            if (o_stat.div_done) begin
                r_pattern <= w_rem_code;
                r_sym     <= '0;
            end
        end else if (i_ctrl.inc_sym) begin
            r_sym <= r_sym + SYM_W'(1);
        end else if (i_ctrl.next_digit) begin
            r_left <= r_left - CNT_W'(1);
            r_sym  <= '0;
            if (r_left > CNT_W'(1)) begin
                r_pattern <= w_rd_code;
            end
        end
    end

    // working value and digit store
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_work <= w_clamped;
        end else if (i_ctrl.div) begin
            r_work                   <= w_quot;
            r_store[r_left[IDX_W-1:0]] <= w_rem;
        end
    end

endmodule

FILE: rtl/mnlb_seq.sv
// microcoded sequencer: step counter, tick timer, handshakes and result register
module mnlb_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mnlb_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mnlb_pkg::t_out_item   o_out_data,
    input  mnlb_pkg::t_cfg        i_cfg,
    output mnlb_pkg::t_dp_ctrl    o_ctrl,
    input  mnlb_pkg::t_dp_stat    i_stat
);
    import mnlb_pkg::*;

    logic [UPC_W-1:0]  r_upc,  n_upc;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data, n_out_data;

    t_uword            w_uw;
    logic              w_out_free;
    logic              w_take;
    logic              w_is_tick;
    logic              w_red;
    logic              w_blue;
    logic              w_green;
    logic [TICK_W-1:0] w_dur;
    logic              w_expire;
    logic              w_cond;
    logic [UPC_W-1:0]  w_jump;

    assign w_uw        = ucode(r_upc);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (w_uw.act == ACT_DIV) || !w_out_free;
    assign w_take      = i_in_valid && !o_in_stall;
    assign w_is_tick   = i_in_data.kind == KIND_TICK;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // leds of the current step
    assign w_red   = w_uw.led == LED_RED;
    assign w_blue  = (w_uw.led == LED_SYM) && !i_stat.is_dash;
    assign w_green = (w_uw.led == LED_SYM) && i_stat.is_dash;

    // length of the current step
    always_comb begin
        unique case (w_uw.dur)
            DUR_SYM:  w_dur = i_stat.is_dash ? i_cfg.dash_ticks : i_cfg.dot_ticks;
            DUR_GAP:  w_dur = i_cfg.gap_ticks;
            DUR_MARK: w_dur = i_cfg.mark_ticks;
            default:  w_dur = i_cfg.mark_ticks;
        endcase
    end

    // a zero length acts like one tick
    assign w_expire = ({1'b0, r_ticks} + (TICK_W + 1)'(1)) >= {1'b0, w_dur};

    // conditional jump
    always_comb begin
        unique case (w_uw.cond)
            COND_ALWAYS:   w_cond = 1'b1;
            COND_DIV_DONE: w_cond = i_stat.div_done;
            COND_SYM_MORE: w_cond = i_stat.sym_more;
            COND_LAST:     w_cond = i_stat.last_digit;
        endcase
    end
    assign w_jump = w_cond ? w_uw.nxt_t : w_uw.nxt_f;

    // step execution
    always_comb begin
        n_upc       = r_upc;
        n_ticks     = r_ticks;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        o_ctrl      = '0;
        unique case (w_uw.act)
            ACT_IDLE: begin
                if (w_take) begin
                    if (!w_is_tick && (i_in_data.number != '0)) begin
                        o_ctrl.start = 1'b1;
                        n_upc        = w_uw.nxt_t;
                        n_ticks      = '0;
                    end else begin
                        n_out_valid         = 1'b1;
                        n_out_data.red_on   = 1'b0;
                        n_out_data.blue_on  = 1'b0;
                        n_out_data.green_on = 1'b0;
                        n_out_data.busy_res = 1'b0;
                    end
                end
            end
            ACT_DIV: begin
                o_ctrl.div = 1'b1;
                n_upc      = w_jump;
                if (w_cond) begin
                    n_ticks             = '0;
                    n_out_valid         = 1'b1;
                    n_out_data.red_on   = 1'b0;
                    n_out_data.blue_on  = !i_stat.first_dash;
                    n_out_data.green_on = i_stat.first_dash;
                    n_out_data.busy_res = 1'b1;
                end
            end
            default: begin
                if (w_take) begin
                    n_out_valid         = 1'b1;
                    n_out_data.red_on   = w_red;
                    n_out_data.blue_on  = w_blue;
                    n_out_data.green_on = w_green;
                    n_out_data.busy_res = 1'b1;
                    if (w_is_tick) begin
                        if (w_expire) begin
                            n_ticks             = '0;
                            n_upc               = w_jump;
                            o_ctrl.inc_sym      = w_uw.act == ACT_INC_SYM;
                            o_ctrl.next_digit   = w_uw.act == ACT_NEXT_DIGIT;
                            n_out_data.busy_res = w_jump != UPC_IDLE;
                        end else begin
                            n_ticks = r_ticks + TICK_W'(1);
                        end
                    end
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= UPC_IDLE;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_ticks     <= n_ticks;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

endmodule

FILE: rtl/morse_number_led_blinker.sv
// morse number led blinker: plays the decimal digits of a number as morse on leds
//
// Input channel (i_in_valid / o_in_stall / i_in_data): a start transaction
// carries a number, a tick transaction advances time by one tick. Every input
// transaction yields exactly one result on the output channel
// (o_out_valid / i_out_stall / o_out_data) with the red, blue and green leds
// and busy_res.
// Tick transactions: one per cycle while not stalled, result registered in
// the cycle after accept. Start transactions while idle: the digit extractor
// produces one digit per cycle (one reciprocal multiply each); the result is
// registered when extraction ends, with o_in_stall high meanwhile. A zero number
// or a start while busy gives its result like a tick, in the cycle after accept.
// Durations come from the apb registers (dot, dash, gap, mark at 0x0..0xC);
// write them only while idle.
// Reset (synchronous, active low) returns to idle with the default durations.
// While the receiver stalls, the held result stays and o_in_stall is raised
// once the result register is full.
module morse_number_led_blinker #(
    parameter int MAX_DIGITS = mnlb_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mnlb_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mnlb_pkg::t_out_item           o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mnlb_pkg::CFG_AW-1:0]   paddr,
    input  logic [mnlb_pkg::CFG_DW-1:0]   pwdata,
    output logic [mnlb_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);
    import mnlb_pkg::*;

    t_cfg     w_cfg;
    t_dp_ctrl w_ctrl;
    t_dp_stat w_stat;

    // configuration registers
    mnlb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // datapath
    mnlb_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_number (i_in_data.number),
        .i_ctrl   (w_ctrl),
        .o_stat   (w_stat)
    );

    // sequencer
    mnlb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg       (w_cfg),
        .o_ctrl      (w_ctrl),
        .i_stat      (w_stat)
    );

    // no input transaction while digits are extracted
    a_div_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.div |-> o_in_stall)
        else $error("input accepted during digit extraction");

    // a start always enters extraction on the next cycle
    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.start |=> w_ctrl.div)
        else $error("start not followed by extraction");

    // at most one led lit in a result
    a_one_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_out_data.red_on, o_out_data.blue_on,
                                  o_out_data.green_on}))
        else $error("more than one led lit");

    // an idle result is dark
    a_idle_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.busy_res) |->
            !(o_out_data.red_on || o_out_data.blue_on || o_out_data.green_on))
        else $error("led lit while not busy");

endmodule

FILE: verif/mnlb_led_checker.sv
// checker for the morse number led blinker: channel monitor, led predictor and scoreboard
`timescale 1ns / 1ps
module mnlb_led_checker #(
    parameter int MAX_DIGITS = mnlb_pkg::MAX_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  mnlb_pkg::t_in_item            i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  mnlb_pkg::t_out_item           i_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mnlb_pkg::CFG_AW-1:0]   paddr,
    input  logic [mnlb_pkg::CFG_DW-1:0]   pwdata,
    input  logic [mnlb_pkg::CFG_DW-1:0]   prdata,
    input  logic                          pready,
    output int                            o_mismatch_cnt,
    output int                            o_pending_cnt,
    output logic                          o_player_busy
);
    import mnlb_pkg::*;

    localparam int SYMS_PER_DIGIT = 5;

    // morse patterns of digits 9 down to 0, bit 4 is sent first, 1 is a dash
    localparam logic [10*PAT_W-1:0] MORSE_TABLE = {
        5'b11110, 5'b11100, 5'b11000, 5'b10000, 5'b00000,
        5'b00001, 5'b00011, 5'b00111, 5'b01111, 5'b11111
    };

    typedef enum logic [2:0] {
        PLAY_IDLE,
        PLAY_SYM,
        PLAY_GAP,
        PLAY_RED1,
        PLAY_DARK1,
        PLAY_RED2,
        PLAY_DARK2
    } t_play_phase;

    // predicted player state
    logic [DIG_W-1:0]  digit_q [MAX_DIGITS];
    int unsigned       digits_left;
    logic [PAT_W-1:0]  pattern;
    logic [SYM_W-1:0]  sym_idx;
    t_play_phase       phase;
    logic [TICK_W-1:0] tick_cnt;
    t_cfg              cfg;

    t_out_item         leds_expected_q [$];
    int                mismatches;

    function automatic logic sym_is_dash();
        return pattern[4 - sym_idx];
    endfunction

    function automatic void load_digit();
        logic [DIG_W-1:0] d;
        d        = digit_q[digits_left - 1];
        pattern  = MORSE_TABLE[d*PAT_W +: PAT_W];
        sym_idx  = '0;
        phase    = PLAY_SYM;
        tick_cnt = '0;
    endfunction

    function automatic t_out_item led_view();
        t_out_item v;
        v.red_on   = (phase == PLAY_RED1) || (phase == PLAY_RED2);
        v.blue_on  = (phase == PLAY_SYM) && !sym_is_dash();
        v.green_on = (phase == PLAY_SYM) && sym_is_dash();
        v.busy_res = 1'b0;
        return v;
    endfunction

    // advance the player by one transaction and return the leds it shows
    function automatic t_out_item predict_leds(input t_in_item it);
        t_out_item         res;
        longint unsigned   num;
        longint unsigned   cap;
        logic [TICK_W-1:0] span;
        int                n;
        if (it.kind == KIND_START) begin
            // a start is only taken while idle, large values are clamped
            if (phase == PLAY_IDLE) begin
                cap = 1;
                for (int k = 0; k < MAX_DIGITS; k++) cap = cap * 10;
                cap = cap - 1;
                num = it.number;
                if (num > cap) num = cap;
                n = 0;
                while (num != 0 && n < MAX_DIGITS) begin
                    digit_q[n] = DIG_W'(num % 10);
                    num = num / 10;
                    n++;
                end
                digits_left = n;
                if (n > 0) load_digit();
            end
            res = led_view();
        end else begin
            res = led_view();
            if (phase != PLAY_IDLE) begin
                case (phase)
                    PLAY_SYM: span = sym_is_dash() ? cfg.dash_ticks : cfg.dot_ticks;
                    PLAY_GAP: span = cfg.gap_ticks;
                    default:  span = cfg.mark_ticks;
                endcase
                if (span == 0) span = 1;
                if (tick_cnt + 1 >= span) begin
                    tick_cnt = '0;
                    case (phase)
                        PLAY_SYM:   phase = PLAY_GAP;
                        PLAY_GAP: begin
                            sym_idx++;
                            phase = (sym_idx < SYMS_PER_DIGIT) ? PLAY_SYM : PLAY_RED1;
                        end
                        PLAY_RED1:  phase = PLAY_DARK1;
                        PLAY_DARK1: phase = (digits_left == 1) ? PLAY_RED2 : PLAY_DARK2;
                        PLAY_RED2:  phase = PLAY_DARK2;
                        default: begin
                            if (digits_left > 0) digits_left--;
                            if (digits_left == 0) begin
                                phase   = PLAY_IDLE;
                                sym_idx = '0;
                            end else begin
                                load_digit();
                            end
                        end
                    endcase
                end else begin
                    tick_cnt++;
                end
            end
        end
        res.busy_res = (phase != PLAY_IDLE);
        return res;
    endfunction

    // monitor, predict and compare
    always @(posedge i_clk) begin
        t_out_item         want;
        logic [TICK_W-1:0] reg_val;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_DIGITS; k++) digit_q[k] = '0;
            digits_left = 0;
            pattern     = '0;
            sym_idx     = '0;
            phase       = PLAY_IDLE;
            tick_cnt    = '0;
            cfg.dot_ticks  = DOT_RST;
            cfg.dash_ticks = DASH_RST;
            cfg.gap_ticks  = GAP_RST;
            cfg.mark_ticks = MARK_RST;
            leds_expected_q.delete();
            mismatches = 0;
        end else begin
            // register writes update the timing copy, reads are compared with it
            if (psel && penable && pready) begin
                case (paddr[3:2])
                    REG_DOT:  reg_val = cfg.dot_ticks;
                    REG_DASH: reg_val = cfg.dash_ticks;
                    REG_GAP:  reg_val = cfg.gap_ticks;
                    default:  reg_val = cfg.mark_ticks;
                endcase
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_DOT:  cfg.dot_ticks  = pwdata[TICK_W-1:0];
                        REG_DASH: cfg.dash_ticks = pwdata[TICK_W-1:0];
                        REG_GAP:  cfg.gap_ticks  = pwdata[TICK_W-1:0];
                        default:  cfg.mark_ticks = pwdata[TICK_W-1:0];
                    endcase
                end else if (prdata !== {{(CFG_DW-TICK_W){1'b0}}, reg_val}) begin
                    $display("%0t: register read at %h, expected %h, actual %h",
                             $time, paddr, {{(CFG_DW-TICK_W){1'b0}}, reg_val}, prdata);
                    mismatches++;
                end
            end

            // input transaction
            if (i_in_valid && !i_in_stall)
                leds_expected_q.push_back(predict_leds(i_in_data));

            // output transaction
            if (i_out_valid && !i_out_stall) begin
                if (leds_expected_q.size() == 0) begin
                    $display("%0t: unexpected led result, expected none, actual red %b",
                             $time, i_out_data.red_on,
                             " blue %b green %b busy %b",
                             i_out_data.blue_on, i_out_data.green_on, i_out_data.busy_res);
                    mismatches++;
                end else begin
                    want = leds_expected_q.pop_front();
                    if (i_out_data.red_on !== want.red_on ||
                        i_out_data.blue_on !== want.blue_on ||
                        i_out_data.green_on !== want.green_on ||
                        i_out_data.busy_res !== want.busy_res) begin
                        $display("%0t: led result differs, expected red %b blue %b green %b",
                                 $time, want.red_on, want.blue_on, want.green_on,
                                 " busy %b, actual red %b blue %b green %b busy %b",
                                 want.busy_res, i_out_data.red_on, i_out_data.blue_on,
                                 i_out_data.green_on, i_out_data.busy_res);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatch_cnt <= mismatches;
        o_pending_cnt  <= leds_expected_q.size();
        o_player_busy  <= (phase != PLAY_IDLE);
    end

endmodule

FILE: verif/tb_morse_number_led_blinker.sv
// testbench top of the morse number led blinker: stimulus, timing setup and verdict
`timescale 1ns / 1ps
module tb_morse_number_led_blinker;
    import mnlb_pkg::*;

    localparam int MAX_DIGITS = MAX_DIGITS_DEF;
    localparam int RUN_LIMIT  = 500000;
    localparam int BUSY_PCT   = 57;
    localparam int LIGHT_PCT  = 10;
    localparam logic [TICK_W-1:0] TICKS_MAX = '1;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    t_in_item          in_data;
    logic              out_valid;
    logic              out_stall;
    t_out_item         out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    int                mismatch_cnt;
    int                pending_cnt;
    logic              player_busy;
    int                tx_idle_pct;
    int                rx_stall_pct;
    int                items_sent;
    int                cycle_cnt;

    morse_number_led_blinker #(.MAX_DIGITS(MAX_DIGITS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    mnlb_led_checker #(.MAX_DIGITS(MAX_DIGITS)) led_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_mismatch_cnt (mismatch_cnt),
        .o_pending_cnt  (pending_cnt),
        .o_player_busy  (player_busy)
    );

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    task automatic set_idle(input t_idle_mode m);
        case (m)
            IDLE_NONE:     begin tx_idle_pct = 0;         rx_stall_pct = 0;         end
            IDLE_SENDER:   begin tx_idle_pct = BUSY_PCT;  rx_stall_pct = 0;         end
            IDLE_RECEIVER: begin tx_idle_pct = 0;         rx_stall_pct = BUSY_PCT;  end
            default:       begin tx_idle_pct = LIGHT_PCT; rx_stall_pct = LIGHT_PCT; end
        endcase
    endtask

    // one input transaction, returns at the edge that accepts it
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_tick();
        t_in_item it;
        it.kind   = KIND_TICK;
        it.number = NUM_W'($urandom);
        send_item(it);
    endtask

    task automatic send_start(input logic [NUM_W-1:0] num);
        t_in_item it;
        it.kind   = KIND_START;
        it.number = num;
        send_item(it);
    endtask

    // start a number and tick until it has been played, with stray starts mixed in
    task automatic play_number(input logic [NUM_W-1:0] num, input int stray_pct);
        send_start(num);
        do begin
            if ($urandom_range(99) < stray_pct) send_start(NUM_W'($urandom));
            send_tick();
        end while (player_busy);
    endtask

    // sender holds off until every result is back
    task automatic wait_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_cnt != 0);
    endtask

    // finish the current number and drain the output channel
    task automatic settle_player();
        do begin
            while (player_busy) send_tick();
            wait_results();
        end while (player_busy);
    endtask

    task automatic apb_access(input logic is_write, input logic [REG_IW-1:0] idx,
                              input logic [TICK_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= {(CFG_DW-TICK_W)'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input logic [TICK_W-1:0] dot, input logic [TICK_W-1:0] dash,
                              input logic [TICK_W-1:0] gap, input logic [TICK_W-1:0] mark);
        apb_access(1'b1, REG_DOT, dot);
        apb_access(1'b1, REG_DASH, dash);
        apb_access(1'b1, REG_GAP, gap);
        apb_access(1'b1, REG_MARK, mark);
    endtask

    task automatic read_timing();
        apb_access(1'b0, REG_DOT, '0);
        apb_access(1'b0, REG_DASH, '0);
        apb_access(1'b0, REG_GAP, '0);
        apb_access(1'b0, REG_MARK, '0);
    endtask

    // mostly short numbers, some zeros and some above the clamp limit
    function automatic logic [NUM_W-1:0] pick_number();
        int          n;
        int unsigned lo;
        case ($urandom_range(15))
            0:       return '0;
            1:       return NUM_W'($urandom_range(20'hFFFFF, 1000000));
            default: begin
                n  = ($urandom_range(3) == 0) ? $urandom_range(MAX_DIGITS, 1)
                                              : $urandom_range(3, 1);
                lo = 1;
                for (int k = 1; k < n; k++) lo = lo * 10;
                return NUM_W'($urandom_range(lo * 10 - 1, lo));
            end
        endcase
    endfunction

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 4) wait_results();
            if ($urandom_range(9) == 0) send_tick();
            else play_number(pick_number(), 3);
        end
        settle_player();
    endtask

    // watchdog
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Mismatches found");
        $finish;
    end

    // main sequence
    initial begin
        int span_hi;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_data    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        items_sent = 0;
        set_idle(IDLE_NONE);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset durations, ticks while idle and a zero start
        read_timing();
        send_tick();
        send_start('0);
        send_tick();
        settle_player();

        // shortest durations: clamp, every digit, start while busy
        set_timing(1, 1, 1, 1);
        read_timing();
        play_number(20'hFFFFF, 0);
        play_number(7, 0);
        send_start(805);
        repeat (3) send_tick();
        send_start(123456);
        settle_player();
        play_number(123460, 0);
        play_number(999999, 0);
        play_number(1000000, 0);
        play_number(0, 0);
        settle_player();

        // uneven durations under light idling
        set_idle(IDLE_BOTH);
        set_timing(2, 3, 1, 2);
        play_number(9, 0);
        play_number(40, 0);
        settle_player();

        // longest dash, played with dot-only digits
        set_timing(1, TICKS_MAX, 2, 1);
        play_number(5, 0);
        play_number(55555, 0);
        settle_player();
        read_timing();

        // longest everything, idle traffic only
        set_timing(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
        read_timing();
        send_start('0);
        send_tick();
        settle_player();

        // random segments, one per idling style
        for (int s = 0; s < 4; s++) begin
            set_idle(t_idle_mode'(s));
            span_hi = (s == 3) ? 5 : 2;
            set_timing(TICK_W'($urandom_range(span_hi, 1)),
                       TICK_W'($urandom_range(span_hi, 1)),
                       TICK_W'($urandom_range(span_hi, 1)),
                       TICK_W'($urandom_range(span_hi, 1)));
            run_random(250);
        end

        settle_player();
        repeat (4 * MAX_DIGITS) @(posedge clk);
        if (mismatch_cnt == 0 && pending_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
